/* hdl/dtts_pkg.sv */
// Shared widths and limits for the duration text parser.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package dtts_pkg;

  localparam int CH_W        = 8;       // one text character
  localparam int SEC_W       = 17;      // seconds result, 0..MAX_SECONDS
  localparam int CNT_W       = 2;       // field count, 0..3
  localparam int ACC_W       = 20;      // digit accumulator, holds MAX_SECONDS * 10 + 9
  localparam int MAX_SECONDS = 24 * 3600;

endpackage

`default_nettype wire

/* hdl/dtts_in_if.sv */
// Character channel of the duration text parser: valid/ready plus ch and last.
// Depends on dtts_pkg for the character width.
`default_nettype none

interface dtts_in_if
  import dtts_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

/* hdl/dtts_out_if.sv */
// Result channel of the duration text parser: valid/ready plus seconds and field count.
// Depends on dtts_pkg for the result widths.
`default_nettype none

interface dtts_out_if
  import dtts_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [SEC_W-1:0] seconds;
  logic [CNT_W-1:0] fields_found;

  modport source (output valid, output seconds, output fields_found, input ready);
  modport sink   (input valid, input seconds, input fields_found, output ready);
endinterface

`default_nettype wire

/* hdl/duration_text_to_seconds.sv */
// Top level of the duration text parser: seconds, mm:ss or hh:mm:ss text to seconds.
// Depends on dtts_pkg, dtts_in_if and dtts_out_if.
`default_nettype none

// Takes one character per cycle on char_in; the transfer with last set closes the
// string and one result appears on result: the duration in seconds (clamped to
// one day) and the number of fields counted. Leading spaces and tabs of a field
// are skipped, field values saturate, a zero byte or any other non-colon after a
// field ends parsing, and fields past the third are ignored. The path is input
// register -> character state update -> snapshot register -> total (constant
// multiply-add and clamp) -> result register; every stage advances together
// whenever the result register is empty or being taken, so a new character is
// accepted each cycle and only a stalled result holds the input back.
module duration_text_to_seconds
  import dtts_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  dtts_in_if.sink    char_in,
  dtts_out_if.source result
);

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_COLON = 8'h3a;
  localparam int              TOT_W    = SEC_W + 12;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_FIELD = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  function automatic logic [SEC_W-1:0] clamp_field(input logic [ACC_W-1:0] v);
    return (v > ACC_W'(MAX_SECONDS)) ? SEC_W'(MAX_SECONDS) : v[SEC_W-1:0];
  endfunction

  logic advance;

  // input register
  logic            s0_valid;
  logic [CH_W-1:0] s0_ch;
  logic            s0_last;

  // parse state
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] field_count, field_count_next;
  logic [SEC_W-1:0] field0, field0_next;
  logic [SEC_W-1:0] field1, field1_next;
  logic [ACC_W-1:0] field_accum, field_accum_next;
  logic             digit_seen, digit_seen_next;

  // snapshot of a closed string
  logic             snap_valid;
  logic [SEC_W-1:0] snap_f0, snap_f1, snap_f2;
  logic [CNT_W-1:0] snap_cnt;
  logic [SEC_W-1:0] fin_f0, fin_f1;

  logic [TOT_W-1:0] total;
  logic [SEC_W-1:0] total_clamped;

  logic is_blank, is_digit;

  assign advance       = !result.valid || result.ready;
  assign char_in.ready = advance;

  assign is_blank = (s0_ch == CH_SPACE) || (s0_ch == CH_TAB);
  assign is_digit = (s0_ch >= CH_ZERO) && (s0_ch <= CH_NINE);

  always_comb begin
    phase_next       = phase;
    field_count_next = field_count;
    field0_next      = field0;
    field1_next      = field1;
    field_accum_next = field_accum;
    digit_seen_next  = digit_seen;
    if (phase != PH_DONE) begin
      if (phase == PH_START && s0_ch == CH_NUL) begin
        phase_next = PH_DONE;
      end else begin
        if (phase == PH_START) begin
          field_count_next = field_count + 2'd1;
          field_accum_next = '0;
          digit_seen_next  = 1'b0;
          phase_next       = PH_FIELD;
        end
        if (digit_seen_next || !is_blank) begin
          if (is_digit) begin
            digit_seen_next = 1'b1;
            if (field_accum_next <= ACC_W'(MAX_SECONDS)) begin
              // accum * 10 + digit; low nibble of '0'..'9' is the digit value
              field_accum_next = ACC_W'({field_accum_next, 3'b000}
                                        + {field_accum_next, 1'b0}
                                        + (ACC_W + 3)'(s0_ch[3:0]));
            end
          end else begin
            if (field_count_next == 2'd1) begin
              field0_next      = clamp_field(field_accum_next);
              field_accum_next = '0;
            end else if (field_count_next == 2'd2) begin
              field1_next      = clamp_field(field_accum_next);
              field_accum_next = '0;
            end
            digit_seen_next = 1'b0;
            phase_next = (s0_ch == CH_COLON && field_count_next != 2'd3) ? PH_START : PH_DONE;
          end
        end
      end
    end
  end

  // an open field is closed at the end of the text
  always_comb begin
    fin_f0 = field0_next;
    fin_f1 = field1_next;
    if (phase_next == PH_FIELD && field_count_next == 2'd1) begin
      fin_f0 = clamp_field(field_accum_next);
    end
    if (phase_next == PH_FIELD && field_count_next == 2'd2) begin
      fin_f1 = clamp_field(field_accum_next);
    end
  end

  always_comb begin
    unique case (snap_cnt)
      2'd3:    total = TOT_W'(snap_f0) * TOT_W'(3600) + TOT_W'(snap_f1) * TOT_W'(60)
                       + TOT_W'(snap_f2);
      2'd2:    total = TOT_W'(snap_f0) * TOT_W'(60) + TOT_W'(snap_f1);
      2'd1:    total = TOT_W'(snap_f0);
      default: total = '0;
    endcase
    total_clamped = (total > TOT_W'(MAX_SECONDS)) ? SEC_W'(MAX_SECONDS) : total[SEC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid     <= 1'b0;
      snap_valid   <= 1'b0;
      result.valid <= 1'b0;
      phase        <= PH_START;
      field_count  <= '0;
      field0       <= '0;
      field1       <= '0;
      field_accum  <= '0;
      digit_seen   <= 1'b0;
    end else if (advance) begin
      s0_valid <= char_in.valid;
      s0_ch    <= char_in.ch;
      s0_last  <= char_in.last;

      snap_valid <= s0_valid && s0_last;
      snap_f0    <= fin_f0;
      snap_f1    <= fin_f1;
      snap_f2    <= clamp_field(field_accum_next);
      snap_cnt   <= field_count_next;

      if (s0_valid) begin
        if (s0_last) begin
          phase       <= PH_START;
          field_count <= '0;
          field0      <= '0;
          field1      <= '0;
          field_accum <= '0;
          digit_seen  <= 1'b0;
        end else begin
          phase       <= phase_next;
          field_count <= field_count_next;
          field0      <= field0_next;
          field1      <= field1_next;
          field_accum <= field_accum_next;
          digit_seen  <= digit_seen_next;
        end
      end

      result.valid        <= snap_valid;
      result.seconds      <= total_clamped;
      result.fields_found <= snap_cnt;
    end
  end

endmodule

`default_nettype wire
